@@ src/sha_pkg.sv @@
`timescale 1ns / 1ps
package sha_pkg;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_EMIT
    } state_t;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

endpackage

@@ src/sha256_hash_engine.sv @@
`timescale 1ns / 1ps
// SHA-256 engine. Message words come in big-endian, four bytes to an item, each with a
// count of valid leading bytes and a last flag; short words join the byte stream without
// gaps. The engine takes one item per cycle while filling a 64-byte block; a full block
// runs the 64 rounds on one shared round unit at one round per cycle, and no item is
// taken until the block has been compressed. On the last item it pads one byte per
// cycle, runs one or two more blocks, then emits the eight digest words, the eighth
// flagged by tlast, and starts over for the next message.
module sha256_hash_engine
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_word[31:0], valid_bytes[34:32], zero fill
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word[31:0]
    output logic        m_tlast
);

    state_t            state_reg, state_next;
    logic [7:0][31:0]  h_reg, h_next;
    logic [15:0][31:0] buf_reg, buf_next;
    logic [31:0]       wrap_reg, wrap_next;
    logic [5:0]        fill_reg, fill_next;
    logic [63:0]       len_reg, len_next;
    logic [63:0]       plen_reg, plen_next;
    logic              final_reg, final_next;
    logic [3:0]        pcnt_reg, pcnt_next;
    logic [2:0]        ocnt_reg, ocnt_next;
    logic [2:0]        nvb;
    logic [31:0]       dw;
    logic              in_fire, out_fire, blk_full;
    logic [7:0][31:0]  h_sum;
    logic              core_start, core_busy, core_done;
    logic [7:0]        pad_b;

    assign dw      = s_tdata[31:0];
    assign nvb     = (s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];
    assign in_fire = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    sha_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (core_start),
        .block (buf_reg),
        .h_in  (h_reg),
        .h_out (h_sum),
        .busy  (core_busy),
        .done  (core_done)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
                if (in_fire)
                begin
                    if (blk_full)
                        state_next = ST_ROUND;
                    else if (s_tlast)
                        state_next = ST_PAD;
                end
            ST_ROUND:  if (core_done) state_next = ST_UPDATE;
            ST_UPDATE: state_next = final_reg ? ST_EMIT : (pcnt_reg != 4'd0 ? ST_PAD : ST_LOAD);
            ST_PAD:
                if (fill_reg == 6'd63) state_next = ST_ROUND;
            ST_EMIT:   if (out_fire && ocnt_reg == 3'd7) state_next = ST_LOAD;
            default:   state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        s_tready   = (state_reg == ST_LOAD);
        m_tvalid   = (state_reg == ST_EMIT);
        m_tdata    = h_reg[ocnt_reg];
        m_tlast    = (ocnt_reg == 3'd7);
        core_start = (state_reg == ST_ROUND) && !core_busy && !core_done;
    end

    // byte insertion helpers
    logic [6:0] pos_end;
    always_comb
    begin
        pos_end  = {1'b0, fill_reg} + {4'd0, nvb};
        blk_full = pos_end[6];
        if (pcnt_reg == 4'd0)
            pad_b = (fill_reg == LEN_POS && pcnt_reg != 4'd0) ? 8'd0 : 8'd0;
        else
            pad_b = plen_reg[63:56];
    end

    always_comb
    begin
        logic [6:0] pe;
        logic [5:0] p;
        logic [3:0] wi;
        logic [4:0] sh;
        buf_next   = buf_reg;
        wrap_next  = wrap_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        plen_next  = plen_reg;
        final_next = final_reg;
        pcnt_next  = pcnt_reg;
        ocnt_next  = ocnt_reg;
        h_next     = h_reg;
        pe = {1'b0, fill_reg};
        p  = fill_reg;
        wi = p[5:2];
        sh = 5'd24 - {p[1:0], 3'd0};
        case (state_reg)
            ST_LOAD:
                if (in_fire)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        if (3'(i) < nvb)
                        begin
                            pe = {1'b0, fill_reg} + 7'(i);
                            p  = pe[5:0];
                            wi = p[5:2];
                            sh = 5'd24 - {p[1:0], 3'd0};
                            if (pe[6])
                            begin
                                if (p[1:0] == 2'd0) wrap_next = '0;
                                wrap_next = wrap_next
                                    | ({24'd0, dw[31 - 8 * i -: 8]} << sh);
                            end
                            else
                            begin
                                if (p[1:0] == 2'd0) buf_next[wi] = '0;
                                buf_next[wi] = buf_next[wi]
                                    | ({24'd0, dw[31 - 8 * i -: 8]} << sh);
                            end
                        end
                    end
                    fill_next = pos_end[5:0];
                    len_next  = len_reg + {58'd0, nvb, 3'd0};
                    if (s_tlast)
                    begin
                        plen_next = len_reg + {58'd0, nvb, 3'd0};
                        pcnt_next = 4'd9;
                    end
                end
            ST_PAD:
            begin
                if (p[1:0] == 2'd0) buf_next[wi] = '0;
                if (pcnt_reg == 4'd9)
                begin
                    buf_next[wi] = buf_next[wi] | ({24'd0, PAD_BYTE} << sh);
                    pcnt_next = (fill_reg == 6'd55) ? 4'd8 : 4'd10;
                end
                else if (pcnt_reg == 4'd10)
                begin
                    if (fill_reg == 6'd55) pcnt_next = 4'd8;
                end
                else
                begin
                    buf_next[wi] = buf_next[wi] | ({24'd0, pad_b} << sh);
                    plen_next = {plen_reg[55:0], 8'd0};
                    pcnt_next = pcnt_reg - 4'd1;
                    if (pcnt_reg == 4'd1) final_next = 1'b1;
                end
                fill_next = fill_reg + 6'd1;
            end
            ST_UPDATE:
            begin
                h_next = h_sum;
                if (fill_reg != 6'd0) buf_next[0] = wrap_reg;
            end
            ST_EMIT:
                if (out_fire)
                begin
                    ocnt_next = ocnt_reg + 3'd1;
                    if (ocnt_reg == 3'd7)
                    begin
                        for (int i = 0; i < 8; i++) h_next[i] = INIT_H[i];
                        fill_next  = '0;
                        len_next   = '0;
                        final_next = 1'b0;
                        pcnt_next  = '0;
                    end
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            for (int i = 0; i < 8; i++) h_reg[i] <= INIT_H[i];
            fill_reg  <= '0;
            len_reg   <= '0;
            final_reg <= 1'b0;
            pcnt_reg  <= '0;
            ocnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            h_reg     <= h_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            final_reg <= final_next;
            pcnt_reg  <= pcnt_next;
            ocnt_reg  <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg  <= buf_next;
        wrap_reg <= wrap_next;
        plen_reg <= plen_next;
    end

    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        core_busy |-> !s_tready)
        else $error("input taken during rounds");
    a_emit_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && m_tlast |=> state_reg == ST_LOAD && len_reg == 64'd0)
        else $error("state not cleared after digest");
    a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !core_busy)
        else $error("digest shown while compressing");

endmodule

@@ src/sha_core.sv @@
`timescale 1ns / 1ps
module sha_core
    import sha_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [15:0][31:0] block,
    input  logic [7:0][31:0]  h_in,
    output logic [7:0][31:0]  h_out,
    output logic              busy,
    output logic              done
);

    logic [15:0][31:0] w_reg, w_next;
    logic [7:0][31:0]  v_reg, v_next;
    logic [5:0]        t_reg, t_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [31:0] x15, x2, s0, s1, wn, wt, a, e, t1, t2;

    always_comb
    begin
        x15 = w_reg[1];
        x2  = w_reg[14];
        s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
        s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
        wn  = w_reg[0] + s0 + w_reg[9] + s1;
        wt  = w_reg[0];
        a   = v_reg[0];
        e   = v_reg[4];
        t1  = v_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & v_reg[5]) ^ (~e & v_reg[6])) + ROUND_K[t_reg] + wt;
        t2  = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_comb
    begin
        w_next    = w_reg;
        v_next    = v_reg;
        t_next    = t_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg)
        begin
            w_next    = block;
            v_next    = h_in;
            t_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            w_next = {wn, w_reg[15:1]};
            v_next = {v_reg[6:4], v_reg[3] + t1, v_reg[2:0], t1 + t2};
            t_next = t_reg + 6'd1;
            if (t_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg    <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            t_reg    <= t_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        v_reg <= v_next;
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            h_out[i] = h_in[i] + v_reg[i];
    end

    assign busy = busy_reg;
    assign done = done_reg;

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && t_reg == 6'd63 |=> done_reg && !busy_reg)
        else $error("round count did not finish");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done longer than one cycle");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("done while busy");

endmodule
